FILE: rtl/dmaarb_pkg.sv
package dmaarb_pkg;

  localparam int NumChannelsDef = 7;

  // control word fields
  localparam logic [31:0] StartTrigMask = 32'h1100_0000;
  localparam logic [31:0] SyncModeMask  = 32'h0000_0600;
  localparam logic [31:0] StartMask     = 32'h0100_0000;
  localparam logic [31:0] Ch6KeepMask   = 32'hAEFF_FFFF;
  localparam logic [31:0] Ch6DataMask   = 32'h5100_0000;
  localparam logic [31:0] Ch6ForceBits  = 32'h0000_0002;

  // interrupt word fields
  localparam logic [31:0] IrqFlagMask   = 32'h7F00_0000;
  localparam logic [31:0] IrqCtlMask    = 32'h00FF_FFFF;
  localparam int          IrqEnBase     = 16;
  localparam int          IrqMasterBit  = 23;
  localparam int          IrqFlagBase   = 24;
  localparam int          IrqForceBit   = 15;

  // address map
  localparam logic [3:0] SubBase  = 4'h0;
  localparam logic [3:0] SubBlock = 4'h4;
  localparam logic [3:0] SubCtrl  = 4'h8;
  localparam logic [7:0] OffPrio  = 8'hF0;
  localparam logic [7:0] OffIrq   = 8'hF4;

  localparam logic [2:0] ChSpecial6 = 3'd6;
  localparam logic [2:0] ChBlkLo3   = 3'd3;
  localparam logic [2:0] ChBlkHi2   = 3'd2;
  localparam logic [1:0] SyncBlock  = 2'd1;

  typedef struct packed {
    logic        op;
    logic        byte_access;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
  } dmaarb_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        grant_valid;
    logic [2:0]  grant_channel;
    logic        irq_raised;
  } dmaarb_rsp_t;

  typedef struct packed {
    logic capture;
    logic access;
    logic arb;
    logic load_out;
  } dmaarb_cmd_t;

  typedef struct packed {
    logic ctrl_write;
    logic out_free;
  } dmaarb_status_t;

endpackage

FILE: rtl/dmaarb_ctrl.sv
module dmaarb_ctrl
  import dmaarb_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dmaarb_status_t status_i,
  output dmaarb_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StAccess = 4'b0010,
    StArb    = 4'b0100,
    StDone   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = StAccess;
      end
      StAccess: begin
        cmd_o.access = 1'b1;
        state_d      = status_i.ctrl_write ? StArb : StDone;
      end
      StArb: begin
        cmd_o.arb = 1'b1;
        state_d   = StDone;
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

endmodule

FILE: rtl/dmaarb_dp.sv
module dmaarb_dp
  import dmaarb_pkg::*;
#(
  parameter int NumChannels = NumChannelsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dmaarb_req_t    in_req_i,
  input  dmaarb_cmd_t    cmd_i,
  output dmaarb_status_t status_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dmaarb_rsp_t    out_rsp_o
);

  localparam int ChW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam logic [2:0] NumChL = 3'(NumChannels);

  logic [31:0] base_q [NumChannels];
  logic [31:0] block_q[NumChannels];
  logic [31:0] ctrl_q [NumChannels];
  logic [31:0] prio_q;
  logic [30:0] irq_q;

  dmaarb_req_t req_q;
  logic [31:0] rd_q;
  logic        gv_q, girq_q;
  logic [2:0]  gch_q;
  dmaarb_rsp_t rsp_q;
  logic        out_valid_q;

  // decode
  logic [7:0]     eff_off;
  logic           in_chan, is_base, is_block, is_ctrl, is_prio, is_irq;
  logic [2:0]     ch3;
  logic [ChW-1:0] ch_idx;
  logic [1:0]     lane;
  logic [31:0]    irq_rd, rword, wval, rd_d, irq_wr;
  logic [6:0]     irq_any;

  always_comb begin
    eff_off  = req_q.byte_access ? {req_q.reg_offset[7:2], 2'b00} : req_q.reg_offset;
    ch3      = eff_off[6:4];
    ch_idx   = eff_off[4 +: ChW];
    lane     = req_q.reg_offset[1:0];
    in_chan  = eff_off[7] && (ch3 < NumChL);
    is_base  = in_chan && (eff_off[3:0] == SubBase);
    is_block = in_chan && (eff_off[3:0] == SubBlock);
    is_ctrl  = in_chan && (eff_off[3:0] == SubCtrl);
    is_prio  = (eff_off == OffPrio);
    is_irq   = (eff_off == OffIrq);

    irq_any = irq_q[IrqEnBase +: 7] & irq_q[IrqFlagBase +: 7];
    irq_rd  = {irq_q[IrqForceBit] | (irq_q[IrqMasterBit] & (|irq_any)), irq_q};

    if (is_base)       rword = base_q[ch_idx];
    else if (is_block) rword = block_q[ch_idx];
    else if (is_ctrl)  rword = ctrl_q[ch_idx];
    else if (is_prio)  rword = prio_q;
    else if (is_irq)   rword = irq_rd;
    else               rword = '0;

    wval = req_q.write_data;
    if (req_q.byte_access) begin
      wval = rword;
      wval[8*lane +: 8] = req_q.write_data[7:0];
    end

    irq_wr = ({1'b0, irq_q} & IrqFlagMask) | (wval & IrqCtlMask);
    irq_wr = irq_wr & ~(wval & IrqFlagMask);

    if (req_q.op)                rd_d = '0;
    else if (req_q.byte_access)  rd_d = {24'd0, rword[8*lane +: 8]};
    else                         rd_d = rword;
  end

  // arbitration: lowest priority value wins, ties to the higher channel
  logic           arb_found;
  logic [2:0]     arb_best, best_pri;
  logic [ChW-1:0] arb_idx;
  logic [31:0]    arb_ctrl;
  logic           arb_irq;

  always_comb begin
    logic [31:0] c;
    logic [3:0]  nib;
    logic        started;
    arb_found = 1'b0;
    arb_best  = '0;
    best_pri  = 3'd7;
    for (int i = 0; i < NumChannels; i++) begin
      c       = ctrl_q[i];
      nib     = prio_q[4*i +: 4];
      started = (c[10:9] == 2'd0) ? ((c & StartTrigMask) == StartTrigMask)
                                  : ((c & StartMask) != '0);
      if (started && nib[3] && (!arb_found || nib[2:0] <= best_pri)) begin
        arb_found = 1'b1;
        best_pri  = nib[2:0];
        arb_best  = 3'(i);
      end
    end
    arb_idx  = arb_best[ChW-1:0];
    arb_ctrl = ctrl_q[arb_idx] & ~StartTrigMask;
    arb_irq  = irq_q[IrqEnBase + 32'(arb_best)] & irq_q[IrqMasterBit];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        base_q[i]  <= '0;
        block_q[i] <= '0;
        ctrl_q[i]  <= '0;
      end
      prio_q <= '0;
      irq_q  <= '0;
    end else if (cmd_i.access && req_q.op) begin
      if (is_base)  base_q[ch_idx]  <= wval;
      if (is_block) block_q[ch_idx] <= wval;
      if (is_ctrl) begin
        if (ch3 == ChSpecial6)
          ctrl_q[ch_idx] <= (ctrl_q[ch_idx] & Ch6KeepMask) | Ch6ForceBits |
                            (wval & Ch6DataMask);
        else
          ctrl_q[ch_idx] <= wval;
      end
      if (is_prio) prio_q <= wval;
      if (is_irq)  irq_q  <= irq_wr[30:0];
    end else if (cmd_i.arb && arb_found) begin
      ctrl_q[arb_idx] <= arb_ctrl;
      if ((arb_best == ChBlkLo3 || arb_best == ChSpecial6) && arb_ctrl[8])
        block_q[arb_idx] <= {block_q[arb_idx][31:16], 16'd0};
      if (arb_best == ChBlkHi2 && arb_ctrl[10:9] == SyncBlock)
        block_q[arb_idx] <= {16'd0, block_q[arb_idx][15:0]};
      if (arb_irq) irq_q[IrqFlagBase + 32'(arb_best)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      gv_q   <= 1'b0;
      gch_q  <= '0;
      girq_q <= 1'b0;
    end else if (cmd_i.access) begin
      rd_q   <= rd_d;
      gv_q   <= 1'b0;
      gch_q  <= '0;
      girq_q <= 1'b0;
    end else if (cmd_i.arb && arb_found) begin
      gv_q   <= 1'b1;
      gch_q  <= arb_best;
      girq_q <= arb_irq;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) rsp_q <= '{read_data: rd_q, grant_valid: gv_q,
                                   grant_channel: gch_q, irq_raised: girq_q};
  end

  assign status_o.ctrl_write = req_q.op && is_ctrl;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_rsp_o           = rsp_q;

`ifndef SYNTHESIS
  a_irq_needs_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.irq_raised |-> out_rsp_o.grant_valid)
    else $error("irq_raised without grant");
  a_no_grant_zero_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.grant_valid |-> out_rsp_o.grant_channel == 3'd0)
    else $error("grant_channel set without grant");
  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.grant_valid |-> out_rsp_o.grant_channel < NumChL)
    else $error("granted channel out of range");
  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.access && req_q.op |=> rd_q == 32'd0)
    else $error("write returned read data");
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !out_valid_q || out_ready_i)
    else $error("response overwritten");
`endif

endmodule

FILE: rtl/dma_channel_register_arbiter.sv
// Channel  Valid        Ready        Payload
// request  in_valid_i   in_ready_o   in_req_i   (op, byte_access, reg_offset, write_data)
// response out_valid_o  out_ready_i  out_rsp_o  (read_data, grant_valid, grant_channel,
//                                                irq_raised)
//
// One request at a time: a read or non-control write passes through access and done
// before reaching the response register, a control-word write through access,
// arbitration and done; the next request is taken once the controller is back in idle.
// Reset is asynchronous, active low; register file and handshake state clear.
// A stalled response holds in the output register; the controller waits in
// done until the slot frees, and takes no request meanwhile.
module dma_channel_register_arbiter
  import dmaarb_pkg::*;
#(
  parameter int NumChannels = NumChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dmaarb_req_t in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output dmaarb_rsp_t out_rsp_o
);

  dmaarb_cmd_t    cmd;
  dmaarb_status_t status;

  // sequencer: idle -> access -> (arbitrate) -> done
  dmaarb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .status_i (status),
    .cmd_o    (cmd)
  );

  // register file, arbiter and response register
  dmaarb_dp #(
    .NumChannels (NumChannels)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .in_req_i,
    .cmd_i     (cmd),
    .status_o  (status),
    .out_valid_o,
    .out_ready_i,
    .out_rsp_o
  );

endmodule

FILE: verif/dma_channel_register_arbiter_tb.sv
`timescale 1ns / 100ps

module dma_channel_register_arbiter_tb;
  import dmaarb_pkg::*;

  localparam logic       OpRead     = 1'b0;
  localparam logic       OpWrite    = 1'b1;
  localparam logic [1:0] SyncManual = 2'd0;     // start needs start + trigger bits
  localparam logic [7:0] ChanBase   = 8'h80;
  localparam int         RandItems  = 1900;

  // Scoreboard: shadow copy of the register file plus the arbiter, and the
  // queue of predicted responses in request order.
  class dmaarb_scoreboard;
    logic [31:0] base_w[NumChannelsDef];
    logic [31:0] count_w[NumChannelsDef];
    logic [31:0] ctrl_w[NumChannelsDef];
    logic [31:0] prio_w;
    logic [31:0] irq_w;
    dmaarb_rsp_t access_rsp_q[$];
    dmaarb_rsp_t pend;
    int errors, reads, writes, grants, irq_grants;

    function new();
      foreach (base_w[i]) begin
        base_w[i]  = '0;
        count_w[i] = '0;
        ctrl_w[i]  = '0;
      end
      prio_w     = '0;
      irq_w      = '0;
      errors     = 0;
      reads      = 0;
      writes     = 0;
      grants     = 0;
      irq_grants = 0;
    endfunction

    // 1 when off is a base, block or control word of an existing channel
    function bit chan_slot(input logic [7:0] off, output int ch);
      ch = (int'(off) - int'(ChanBase)) >> 4;
      if (off < ChanBase || int'(off) >= int'(ChanBase) + 16 * NumChannelsDef)
        return 1'b0;
      return off[3:0] == SubBase || off[3:0] == SubBlock || off[3:0] == SubCtrl;
    endfunction

    function logic [31:0] reg_read(input logic [7:0] off);
      int ch;
      logic [31:0] v;
      if (chan_slot(off, ch)) begin
        case (off[3:0])
          SubBase:  return base_w[ch];
          SubBlock: return count_w[ch];
          default:  return ctrl_w[ch];
        endcase
      end
      if (off == OffPrio)
        return prio_w;
      if (off == OffIrq) begin
        v = irq_w;
        // summary bit: force, or master enable with any enabled flag pending
        if (v[IrqForceBit] || (v[IrqMasterBit] &&
            (v[IrqEnBase +: NumChannelsDef] & v[IrqFlagBase +: NumChannelsDef]) != '0))
          v[31] = 1'b1;
        return v;
      end
      return '0;
    endfunction

    // lowest priority value wins, ties go to the higher channel
    function void grant_next();
      int win;
      int best_pri;
      logic [3:0] nib;
      logic [31:0] c;
      bit started;
      win = -1;
      best_pri = 8;
      for (int i = 0; i < NumChannelsDef; i++) begin
        c = ctrl_w[i];
        started = (c[10:9] == SyncManual) ? ((c & StartTrigMask) == StartTrigMask)
                                          : ((c & StartMask) != '0);
        nib = prio_w[4*i +: 4];
        if (started && nib[3] && int'(nib[2:0]) <= best_pri) begin
          best_pri = int'(nib[2:0]);
          win = i;
        end
      end
      if (win < 0)
        return;
      c = ctrl_w[win] & ~StartTrigMask;
      ctrl_w[win] = c;
      if ((win == ChSpecial6 || win == ChBlkLo3) && c[8])
        count_w[win][15:0] = '0;
      if (win == ChBlkHi2 && c[10:9] == SyncBlock)
        count_w[win][31:16] = '0;
      pend.grant_valid   = 1'b1;
      pend.grant_channel = 3'(win);
      if (irq_w[IrqEnBase + win] && irq_w[IrqMasterBit]) begin
        irq_w[IrqFlagBase + win] = 1'b1;
        pend.irq_raised = 1'b1;
      end
    endfunction

    function void reg_write(input logic [7:0] off, input logic [31:0] w);
      int ch;
      if (chan_slot(off, ch)) begin
        case (off[3:0])
          SubBase:  base_w[ch] = w;
          SubBlock: count_w[ch] = w;
          default: begin
            if (ch == ChSpecial6)
              ctrl_w[ch] = (ctrl_w[ch] & Ch6KeepMask) | Ch6ForceBits | (w & Ch6DataMask);
            else
              ctrl_w[ch] = w;
            grant_next();
          end
        endcase
      end else if (off == OffPrio) begin
        prio_w = w;
      end else if (off == OffIrq) begin
        // control bits load, flags written as one clear
        irq_w = ((irq_w & IrqFlagMask) | (w & IrqCtlMask)) & ~(w & IrqFlagMask);
      end
    endfunction

    function void note_access(input dmaarb_req_t req);
      logic [7:0] word_off;
      int sh;
      logic [31:0] w;
      pend = '0;
      if (req.op == OpWrite) writes++;
      else reads++;
      if (req.byte_access) begin
        // byte lanes work on the containing word, writes as read-modify-write
        word_off = req.reg_offset & 8'hFC;
        sh = 8 * int'(req.reg_offset[1:0]);
        w = reg_read(word_off);
        if (req.op == OpWrite) begin
          w[sh +: 8] = req.write_data[7:0];
          reg_write(word_off, w);
        end else begin
          pend.read_data = {24'h0, w[sh +: 8]};
        end
      end else if (req.op == OpWrite) begin
        reg_write(req.reg_offset, req.write_data);
      end else begin
        pend.read_data = reg_read(req.reg_offset);
      end
      access_rsp_q.push_back(pend);
    endfunction

    function void cmp_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(input dmaarb_rsp_t got);
      dmaarb_rsp_t want;
      if (access_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: response with no request pending: expected none, actual 0x%0h",
                 $time, got);
        return;
      end
      want = access_rsp_q.pop_front();
      if (want.grant_valid) grants++;
      if (want.irq_raised) irq_grants++;
      cmp_field("read_data", want.read_data, got.read_data);
      cmp_field("grant_valid", 32'(want.grant_valid), 32'(got.grant_valid));
      cmp_field("grant_channel", 32'(want.grant_channel), 32'(got.grant_channel));
      cmp_field("irq_raised", 32'(want.irq_raised), 32'(got.irq_raised));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  dmaarb_req_t in_req_i    = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  dmaarb_rsp_t out_rsp_o;

  bit steady = 1'b0;    // when set, neither side idles
  int ready_hold = 0;

  dmaarb_scoreboard sb = new();

  dma_channel_register_arbiter #(
    .NumChannels(NumChannelsDef)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic dmaarb_req_t bus_req(input logic op, input logic byt,
                                          input logic [7:0] off, input logic [31:0] d);
    dmaarb_req_t r;
    r.op          = op;
    r.byte_access = byt;
    r.reg_offset  = off;
    r.write_data  = d;
    return r;
  endfunction

  function automatic logic [7:0] chan_reg(input int ch, input logic [3:0] sub);
    return ChanBase + 8'(ch * 16) + 8'(sub);
  endfunction

  // Random request: mostly mapped registers with data shaped so channels
  // actually start and arbitrate, plus some fully random offsets.
  function automatic dmaarb_req_t rand_access();
    logic [7:0] off;
    logic [31:0] w;
    logic [31:0] d;
    logic [3:0] sub;
    int pick;
    logic op;
    logic byt;
    op  = ($urandom_range(0, 9) < 6) ? OpWrite : OpRead;
    byt = ($urandom_range(0, 5) == 0);
    w   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      off = 8'($urandom_range(0, 255));
    end else begin
      if (pick < 22) begin
        off = OffPrio;
        if ($urandom_range(0, 9) < 6) w |= 32'h8888_8888;   // enables
        if ($urandom_range(0, 9) < 5) w &= ~32'h6666_6666;  // crowd priorities, force ties
      end else if (pick < 30) begin
        off = OffIrq;
        if ($urandom_range(0, 9) < 6) w[23:16] = 8'hFF;
        if ($urandom_range(0, 9) < 5) w[30:24] = '0;        // leave flags standing
      end else begin
        case ($urandom_range(0, 3))
          0:       sub = SubBase;
          1:       sub = SubBlock;
          default: sub = SubCtrl;
        endcase
        off = chan_reg($urandom_range(0, NumChannelsDef - 1), sub);
        if (sub == SubCtrl) begin
          if ($urandom_range(0, 9) < 7) w[24] = 1'b1;
          if ($urandom_range(0, 9) < 6) w[28] = 1'b1;
          if ($urandom_range(0, 2) == 0) w[10:9] = SyncManual;
        end
      end
      if (byt) off[1:0] = 2'($urandom_range(0, 3));
    end
    d = w;
    if (byt) begin
      // shaped byte lands in the lane being written, rest is noise
      d = w >> (8 * int'(off[1:0]));
      d[31:8] = 24'($urandom);
    end
    return bus_req(op, byt, off, d);
  endfunction

  // Request side: optional gap, then hold valid until accepted. Valid is
  // only dropped when a gap follows, so back-to-back requests keep it high.
  task automatic send_access(input dmaarb_req_t req);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(req);
  endtask

  // Response side: checks every accepted response, toggles ready in runs.
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(out_rsp_o);
      if (steady) begin
        out_ready_i <= 1'b1;
        ready_hold = 0;
      end else if (ready_hold == 0) begin
        out_ready_i <= ($urandom_range(0, 9) < 6);
        ready_hold = pick_gap();
      end else begin
        ready_hold--;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value, then everything enabled at the lowest priority
    send_access(bus_req(OpRead, 1'b0, chan_reg(0, SubCtrl), 32'h0));
    send_access(bus_req(OpWrite, 1'b0, OffPrio, 32'hFFFF_FFFF));
    send_access(bus_req(OpWrite, 1'b0, OffIrq, 32'h00FF_FFFF));
    send_access(bus_req(OpRead, 1'b0, OffIrq, 32'hFFFF_FFFF));
    // manual mode start+trigger grant with interrupt, then summary bit read
    send_access(bus_req(OpWrite, 1'b0, chan_reg(5, SubCtrl), 32'h1100_0000));
    send_access(bus_req(OpRead, 1'b0, OffIrq, 32'h0));
    // block mode: start alone is enough; manual mode: start alone is not
    send_access(bus_req(OpWrite, 1'b0, chan_reg(4, SubCtrl), 32'h0100_0200));
    send_access(bus_req(OpWrite, 1'b0, chan_reg(0, SubCtrl), 32'h0100_0000));
    // park three channels while disabled, then release them with equal priority
    send_access(bus_req(OpWrite, 1'b0, OffPrio, 32'h0000_0000));
    send_access(bus_req(OpWrite, 1'b0, chan_reg(2, SubBlock), 32'hFFFF_FFFF));
    send_access(bus_req(OpWrite, 1'b0, chan_reg(3, SubBlock), 32'hFFFF_FFFF));
    send_access(bus_req(OpWrite, 1'b0, chan_reg(1, SubCtrl), 32'h1100_0000));
    send_access(bus_req(OpWrite, 1'b0, chan_reg(3, SubCtrl), 32'h1100_0100));
    send_access(bus_req(OpWrite, 1'b0, chan_reg(2, SubCtrl), 32'h0100_0200));
    send_access(bus_req(OpWrite, 1'b0, OffPrio, 32'h8888_8888));
    // tie break from the top: ch3 (low block half clear), ch2 (high half), ch1
    send_access(bus_req(OpWrite, 1'b0, chan_reg(0, SubCtrl), 32'h0));
    send_access(bus_req(OpWrite, 1'b0, chan_reg(0, SubCtrl), 32'h0));
    send_access(bus_req(OpWrite, 1'b0, chan_reg(0, SubCtrl), 32'h0));
    // channel 6 control write masks, byte read of its top lane
    send_access(bus_req(OpWrite, 1'b0, chan_reg(6, SubCtrl), 32'hFFFF_FFFF));
    send_access(bus_req(OpRead, 1'b1, chan_reg(6, SubCtrl) | 8'h3, 32'h0));
    // clear flags by writing ones; byte write sets the force bit via merge
    send_access(bus_req(OpWrite, 1'b0, OffIrq, 32'h7F00_0000));
    send_access(bus_req(OpWrite, 1'b1, OffIrq | 8'h1, 32'hFFFF_FF80));
    send_access(bus_req(OpRead, 1'b1, OffIrq | 8'h3, 32'h0));
    // byte write into a control word starts the channel
    send_access(bus_req(OpWrite, 1'b1, chan_reg(0, SubCtrl) | 8'h3, 32'h0000_0011));
    // unaligned and unmapped word accesses
    send_access(bus_req(OpWrite, 1'b0, 8'hFF, 32'hFFFF_FFFF));
    send_access(bus_req(OpRead, 1'b0, 8'h81, 32'h0));
    send_access(bus_req(OpRead, 1'b0, 8'hFC, 32'h0));

    // random traffic; every fifth stretch runs with no idling at all
    for (int k = 0; k < RandItems; k++) begin
      steady = ((k / 150) % 5 == 4);
      send_access(rand_access());
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.access_rsp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d reads and %0d writes (word and byte, mapped and unmapped).",
             sb.reads, sb.writes);
    $display("Arbitration granted %0d times, %0d of them raising an interrupt flag.",
             sb.grants, sb.irq_grants);
    if (sb.errors == 0 && sb.access_rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
